// File: hdl/tti_pkg.sv
package tti_pkg;

    localparam int unsigned MaxPointsDefault = 1024;
    localparam int unsigned FieldCount = 6;
    localparam int unsigned WordWidth = 32;
    localparam int unsigned CountWidth = 11;
    localparam int unsigned IndexWidth = 10;
    localparam int unsigned DistWidth = 33;
    localparam int unsigned ProdWidth = 66;

    localparam logic CmdLoad = 1'b0;
    localparam logic CmdQuery = 1'b1;

    localparam int unsigned TimeField = 5;

    // controller to datapath commands
    typedef struct packed {
        logic load_query;
        logic store_write;
        logic scan_step;
        logic pick_base;
        logic read_lo;
        logic read_hi;
        logic dist_calc;
        logic div_start;
        logic div_step;
        logic div_next_field;
    } tti_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic zero_span;
    } tti_status_t;

endpackage

// File: hdl/tti_datapath.sv
module tti_datapath #(
    parameter int unsigned MAX_POINTS = tti_pkg::MaxPointsDefault,
    parameter int unsigned ADDR_W = $clog2(MAX_POINTS)
) (
    input  logic                        clk,
    input  tti_pkg::tti_cmd_t           cmd,
    output tti_pkg::tti_status_t        stat,
    input  logic [ADDR_W-1:0]           scan_addr,
    input  logic [ADDR_W:0]             count_eff,
    input  logic [tti_pkg::IndexWidth-1:0] point_index,
    input  logic [tti_pkg::WordWidth-1:0]  in_word [tti_pkg::FieldCount],
    input  logic [2:0]                  field_sel,
    output logic [tti_pkg::WordWidth-1:0]  res_word [tti_pkg::FieldCount],
    output logic                        res_status
);
    import tti_pkg::*;

    localparam int unsigned RowW = FieldCount * WordWidth;

    logic [RowW-1:0] mem [MAX_POINTS];
    logic [RowW-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic [WordWidth-1:0] query_reg;
    logic [DistWidth-1:0] best_dist_reg;
    logic [ADDR_W-1:0] best_reg;
    logic best_le_reg;
    logic scan_first_reg;
    logic [ADDR_W-1:0] prev_addr_reg;
    logic prev_valid_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [RowW-1:0] lo_row_reg;
    logic [RowW-1:0] hi_row_reg;
    logic [DistWidth-1:0] d1_reg;
    logic [DistWidth-1:0] d2_reg;
    logic [ProdWidth:0] num_reg;
    logic [DistWidth:0] rem_reg;
    logic [WordWidth-1:0] quo_reg;
    logic zero_reg;
    logic [WordWidth-1:0] res_reg [FieldCount];
    logic res_status_reg;

    logic [WordWidth-1:0] t_rd;
    logic signed [DistWidth:0] delta;
    logic [DistWidth-1:0] time_gap;
    logic [WordWidth-1:0] lo_w;
    logic [WordWidth-1:0] hi_w;
    logic [WordWidth-1:0] lo_b;
    logic [WordWidth-1:0] hi_b;
    logic [WordWidth+DistWidth-1:0] prod_lo;
    logic [WordWidth+DistWidth-1:0] prod_hi;
    logic [DistWidth:0] sum;
    logic [DistWidth+1:0] trial;
    logic [RowW-1:0] wr_row;
    logic [ADDR_W-1:0] base_hi;

    function automatic logic [DistWidth-1:0] dist_of(input logic [WordWidth-1:0] a,
                                                     input logic [WordWidth-1:0] b);
        logic signed [DistWidth:0] d;
        d = $signed({2'b00, a}) - $signed({2'b00, b});
        return d[DistWidth] ? DistWidth'(-d) : DistWidth'(d);
    endfunction

    // biased store values: flip the sign bit so words compare unsigned
    always_comb
    begin
        for (int f = 0; f < FieldCount; f++)
        begin
            wr_row[f*WordWidth +: WordWidth] = in_word[f] ^ {1'b1, {(WordWidth-1){1'b0}}};
        end
    end

    // select the read address for scan or pair fetch
    always_comb
    begin
        base_hi = base_reg + 1'b1;
        if (cmd.read_lo)
        begin
            rd_addr = base_reg;
        end
        else if (cmd.read_hi)
        begin
            rd_addr = base_hi;
        end
        else
        begin
            rd_addr = scan_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_write && (32'(point_index) < MAX_POINTS))
        begin
            mem[ADDR_W'(point_index)] <= wr_row;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign t_rd = rd_data_reg[TimeField*WordWidth +: WordWidth];
    assign delta = $signed({2'b00, query_reg}) - $signed({2'b00, t_rd});
    assign time_gap = delta[DistWidth] ? DistWidth'(-delta) : DistWidth'(delta);

    // nearest-in-time scan, one stored point a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            query_reg <= in_word[TimeField] ^ {1'b1, {(WordWidth-1){1'b0}}};
            scan_first_reg <= 1'b1;
        end
        if (cmd.scan_step)
        begin
            prev_addr_reg <= scan_addr;
            prev_valid_reg <= 1'b1;
        end
        else
        begin
            prev_valid_reg <= 1'b0;
        end
        if (prev_valid_reg && !cmd.pick_base && !cmd.load_query)
        begin
            scan_first_reg <= 1'b0;
            if (scan_first_reg || time_gap < best_dist_reg)
            begin
                best_dist_reg <= time_gap;
                best_reg <= prev_addr_reg;
                best_le_reg <= delta[DistWidth] || (delta == '0);
            end
        end
        if (cmd.pick_base)
        begin
            if (best_le_reg)
            begin
                base_reg <= (best_reg == '0) ? '0 : best_reg - 1'b1;
            end
            else if ({1'b0, best_reg} == count_eff - 1'b1)
            begin
                base_reg <= ADDR_W'(count_eff - 2'd2);
            end
            else
            begin
                base_reg <= best_reg;
            end
        end
    end

    // pair fetch, distances and bit-serial restoring division
    always_comb
    begin
        lo_w = lo_row_reg[field_sel*WordWidth +: WordWidth];
        hi_w = hi_row_reg[field_sel*WordWidth +: WordWidth];
        lo_b = lo_w;
        hi_b = hi_w;
        prod_lo = lo_b * d2_reg;
        prod_hi = hi_b * d1_reg;
        sum = {1'b0, d1_reg} + {1'b0, d2_reg};
        trial = {rem_reg, num_reg[ProdWidth]} - {1'b0, sum};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_hi)
        begin
            lo_row_reg <= rd_data_reg;
        end
        if (cmd.dist_calc)
        begin
            hi_row_reg <= rd_data_reg;
            d1_reg <= dist_of(query_reg, lo_row_reg[TimeField*WordWidth +: WordWidth]);
            d2_reg <= dist_of(query_reg, t_rd);
        end
        if (cmd.div_start)
        begin
            num_reg <= (ProdWidth+1)'(prod_lo) + (ProdWidth+1)'(prod_hi);
            rem_reg <= '0;
            quo_reg <= '0;
            zero_reg <= (sum == '0);
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[ProdWidth-1:0], 1'b0};
            if (!trial[DistWidth+1])
            begin
                rem_reg <= trial[DistWidth:0];
                quo_reg <= {quo_reg[WordWidth-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DistWidth-1:0], num_reg[ProdWidth]};
                quo_reg <= {quo_reg[WordWidth-2:0], 1'b0};
            end
        end
        if (cmd.div_next_field)
        begin
            res_reg[field_sel] <= (zero_reg ? lo_w : quo_reg) ^ {1'b1, {(WordWidth-1){1'b0}}};
            res_status_reg <= zero_reg;
        end
    end

    assign stat.zero_span = zero_reg;
    assign res_word = res_reg;
    assign res_status = res_status_reg;

endmodule

// File: hdl/tti_controller.sv
module tti_controller #(
    parameter int unsigned MAX_POINTS = tti_pkg::MaxPointsDefault,
    parameter int unsigned ADDR_W = $clog2(MAX_POINTS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  command,
    input  logic [tti_pkg::CountWidth-1:0] point_count,
    input  tti_pkg::tti_status_t  stat,
    output tti_pkg::tti_cmd_t     cmd,
    output logic [ADDR_W-1:0]     scan_addr,
    output logic [ADDR_W:0]       count_eff,
    output logic [2:0]            field_sel,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_ready
);
    import tti_pkg::*;

    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StScan  = 4'd1;
    localparam logic [3:0] StDrain = 4'd2;
    localparam logic [3:0] StDrain2 = 4'd3;
    localparam logic [3:0] StPick  = 4'd4;
    localparam logic [3:0] StRdLo  = 4'd5;
    localparam logic [3:0] StRdHi  = 4'd6;
    localparam logic [3:0] StDist  = 4'd7;
    localparam logic [3:0] StDivIn = 4'd8;
    localparam logic [3:0] StDiv   = 4'd9;
    localparam logic [3:0] StStore = 4'd10;
    localparam logic [3:0] StOut   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [ADDR_W:0] cnt_reg, cnt_next;
    logic [2:0] field_reg, field_next;
    logic [6:0] bit_reg, bit_next;

    // clamp point count to the supported range
    always_comb
    begin
        if (point_count < 11'd2)
        begin
            count_eff = (ADDR_W+1)'(2);
        end
        else if ({{(32-CountWidth){1'b0}}, point_count} > MAX_POINTS)
        begin
            count_eff = (ADDR_W+1)'(MAX_POINTS);
        end
        else
        begin
            count_eff = (ADDR_W+1)'(point_count);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        field_next = field_reg;
        bit_next = bit_reg;
        cmd = '0;
        case (state_reg)
            StIdle:
            begin
                if (in_fire)
                begin
                    if (command == CmdLoad)
                    begin
                        cmd.store_write = 1'b1;
                    end
                    else
                    begin
                        cmd.load_query = 1'b1;
                        cnt_next = '0;
                        state_next = StScan;
                    end
                end
            end
            StScan:
            begin
                cmd.scan_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == count_eff)
                begin
                    state_next = StDrain;
                end
            end
            StDrain: state_next = StDrain2;
            StDrain2: state_next = StPick;
            StPick:
            begin
                cmd.pick_base = 1'b1;
                state_next = StRdLo;
            end
            StRdLo:
            begin
                cmd.read_lo = 1'b1;
                state_next = StRdHi;
            end
            StRdHi:
            begin
                cmd.read_hi = 1'b1;
                state_next = StDist;
            end
            StDist:
            begin
                cmd.dist_calc = 1'b1;
                field_next = '0;
                state_next = StDivIn;
            end
            StDivIn:
            begin
                cmd.div_start = 1'b1;
                bit_next = 7'd67;
                state_next = StDiv;
            end
            StDiv:
            begin
                if (stat.zero_span || bit_reg == '0)
                begin
                    state_next = StStore;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    bit_next = bit_reg - 1'b1;
                end
            end
            StStore:
            begin
                cmd.div_next_field = 1'b1;
                if (field_reg == 3'(FieldCount - 1))
                begin
                    state_next = StOut;
                end
                else
                begin
                    field_next = field_reg + 1'b1;
                    state_next = StDivIn;
                end
            end
            StOut:
            begin
                if (out_ready)
                begin
                    state_next = StIdle;
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            cnt_reg <= '0;
            field_reg <= '0;
            bit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            field_reg <= field_next;
            bit_reg <= bit_next;
        end
    end

    assign scan_addr = cnt_reg[ADDR_W-1:0];
    assign field_sel = field_reg;
    assign busy = (state_reg != StIdle);
    assign out_valid = (state_reg == StOut);

endmodule

// File: hdl/trajectory_time_interpolator.sv
// Trajectory time interpolator.
// Input channel in_valid/in_ready carries one transaction per item: command 0
// loads a trajectory point into slot point_index, command 1 queries at
// time_stamp. A load completes in the cycle it is accepted and gives no result.
// A query gives one result transaction on out_valid/out_ready.
// Configuration channel cfg_valid/cfg_ready writes point_count; write it only
// while no query is in flight. Values below 2 act as 2, above MAX_POINTS act as
// MAX_POINTS.
// For a query, from acceptance to out_valid: the scan reads one stored point
// a cycle from the table memory, the controller then picks and fetches the
// bracketing pair, and one shared bit-serial divider produces the six fields
// in turn, each with 67 quotient steps plus set-up, finish and store. With a
// zero time span a field skips the quotient steps: set-up, finish and store.
// One query is processed at a time; in_ready is low from acceptance until the
// result transaction completes. While the receiver stalls the result holds.
// Reset returns the controller to idle and point_count to 2; the table content
// is undefined until loaded.
module trajectory_time_interpolator #(
    parameter int unsigned MAX_POINTS = tti_pkg::MaxPointsDefault
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic command,
    input  logic [9:0] point_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] heading,
    input  logic signed [31:0] speed,
    input  logic signed [31:0] turn_rate,
    input  logic signed [31:0] time_stamp,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [10:0] cfg_data,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_heading,
    output logic signed [31:0] out_speed,
    output logic signed [31:0] out_turn_rate,
    output logic signed [31:0] out_time,
    output logic status
);
    import tti_pkg::*;

    localparam int unsigned AddrW = $clog2(MAX_POINTS);

    tti_cmd_t cmd;
    tti_status_t stat;
    logic [AddrW-1:0] scan_addr;
    logic [AddrW:0] count_eff;
    logic [2:0] field_sel;
    logic busy;
    logic [CountWidth-1:0] count_reg;
    logic [WordWidth-1:0] in_word [FieldCount];
    logic [WordWidth-1:0] res_word [FieldCount];

    // hold the point count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 11'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready = !busy;

    assign in_word[0] = pos_x;
    assign in_word[1] = pos_y;
    assign in_word[2] = heading;
    assign in_word[3] = speed;
    assign in_word[4] = turn_rate;
    assign in_word[5] = time_stamp;

    tti_controller #(.MAX_POINTS(MAX_POINTS), .ADDR_W(AddrW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_valid && in_ready), .command(command),
        .point_count(count_reg), .stat(stat), .cmd(cmd), .scan_addr(scan_addr),
        .count_eff(count_eff), .field_sel(field_sel), .busy(busy),
        .out_valid(out_valid), .out_ready(out_ready)
    );

    tti_datapath #(.MAX_POINTS(MAX_POINTS), .ADDR_W(AddrW)) u_dp (
        .clk(clk), .cmd(cmd), .stat(stat), .scan_addr(scan_addr),
        .count_eff(count_eff), .point_index(point_index), .in_word(in_word),
        .field_sel(field_sel), .res_word(res_word), .res_status(status)
    );

    assign out_x = res_word[0];
    assign out_y = res_word[1];
    assign out_heading = res_word[2];
    assign out_speed = res_word[3];
    assign out_turn_rate = res_word[4];
    assign out_time = res_word[5];

endmodule
